/* src/tilt_kalman_pd_stage_macros.svh */
// Assertion macros for the tilt Kalman PD stage.
// Included by tilt_kalman_pd_stage, the module that carries concurrent assertions.
`ifndef TILT_KALMAN_PD_STAGE_MACROS_SVH
`define TILT_KALMAN_PD_STAGE_MACROS_SVH

// Implication checked every clock, off while in reset.
`define TK_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tkpd_pkg.sv */
// Shared types and constants of the tilt Kalman PD stage.
// No dependencies.
package tkpd_pkg;

  localparam logic [2:0] RegQAngle = 3'd0;
  localparam logic [2:0] RegQBias  = 3'd1;
  localparam logic [2:0] RegRAngle = 3'd2;
  localparam logic [2:0] RegStep   = 3'd3;
  localparam logic [2:0] RegAccel  = 3'd4;
  localparam logic [2:0] RegProp   = 3'd5;
  localparam logic [2:0] RegDeriv  = 3'd6;
  localparam logic [2:0] RegSetpt  = 3'd7;

  typedef enum logic [4:0] {
    StIdle,
    StMeas,
    StRate,
    StAng0,
    StAng1,
    StCaa,
    StCab,
    StCbb,
    StErr,
    StDivStart,
    StDiv0,
    StDiv1Start,
    StDiv1,
    StUpd0,
    StUpd1,
    StUpd2,
    StUpd3,
    StUpd4,
    StUpd5,
    StFinal,
    StPd0,
    StPd1,
    StPd2,
    StOut
  } state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [31:0] quot;
  } div_rsp_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sd2147483647) r = 32'h7fffffff;
    else if (v < -66'sd2147483648) r = 32'h80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* src/tkpd_div.sv */
// Bit-serial Q-format divider for the Kalman gain: sat32((num << frac) / den).
// Uses tkpd_pkg for the request/response structs.
module tkpd_div #(
  parameter int unsigned FracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tkpd_pkg::div_req_t req_i,
  output tkpd_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NumW = 32 + FracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;     // shifting dividend magnitude
  logic [32:0]     rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [31:0]     den_q, den_d;     // divisor magnitude
  logic            neg_q, neg_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [31:0]     res_q, res_d;

  logic [32:0]     trial;
  logic [NumW:0]   mag;
  logic [31:0]     num_abs;
  logic [31:0]     den_abs;

  always_comb begin
    num_abs = req_i.num[31] ? (~req_i.num + 32'd1) : req_i.num;
    den_abs = req_i.den[31] ? (~req_i.den + 32'd1) : req_i.den;
    num_d   = num_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    neg_d   = neg_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    res_d   = res_q;
    trial   = '0;
    mag     = '0;
    if (req_i.start) begin
      if (req_i.den == '0) begin
        done_d = 1'b1;
        if (req_i.num == '0) res_d = '0;
        else if (req_i.num[31]) res_d = 32'h80000000;
        else res_d = 32'h7fffffff;
      end else begin
        num_d  = {num_abs, {FracBits{1'b0}}};
        den_d  = den_abs;
        neg_d  = req_i.num[31] ^ req_i.den[31];
        rem_d  = '0;
        quo_d  = '0;
        cnt_d  = CntW'(NumW);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      trial = {rem_q[31:0], num_q[NumW-1]};
      num_d = {num_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        mag    = {1'b0, quo_d};
        if (neg_q) res_d = tkpd_pkg::sat32(-$signed(66'(mag)));
        else res_d = tkpd_pkg::sat32($signed(66'(mag)));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = res_q;

endmodule

/* src/tilt_kalman_pd_stage.sv */
// Top level of the tilt Kalman PD stage: sequencer, shared multiplier, state.
// Depends on tkpd_pkg, tkpd_div and tilt_kalman_pd_stage_macros.svh.
`include "tilt_kalman_pd_stage_macros.svh"

// One sample in, one result out. A sequencer walks the predict, correct and
// PD steps through a single shared 32x32 multiplier with a saturating adder
// behind it; the two Kalman gains come from a bit-serial divider, one after
// the other. s_axis_tready is low while a sample is being worked on, so a new
// sample is not taken before the last one is through. The result waits in an
// output register; the next sample is taken once that result has been
// transferred.
module tilt_kalman_pd_stage #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // gyro_raw, accel_x, accel_z, velocity_term
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // drive, filtered_angle, corrected_rate
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [31:0] One = 32'(1) << FRAC_BITS;

  tkpd_pkg::state_e state_q, state_d;

  logic [31:0] q_angle_q, q_bias_q, r_angle_q, step_q, accel_q, prop_q, deriv_q;
  logic [15:0] setpt_q;
  logic [31:0] ang_q, bias_q, caa_q, cab_q, cba_q, cbb_q;
  logic [31:0] ang_d, bias_d, caa_d, cab_d, cba_d, cbb_d;
  logic [15:0] gyro_q, ax_q, az_q, vt_q;
  logic [31:0] meas_q, rate_q, err_q, k0_q, k1_q, t0_q, t1_q, e_q;
  logic [31:0] meas_d, rate_d, err_d, k0_d, k1_d, t0_d, t1_d, e_d;
  logic [31:0] acc_q, acc_d;       // general scratch
  logic [65:0] pacc_q, pacc_d;     // PD sum
  logic [15:0] ai_q, ai_d;
  logic [31:0] drive_q, drive_d, corr_q, corr_d;
  logic        out_valid_q, out_valid_d;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] pshift;
  logic [31:0] prod_q;     // Q-scaled sat32
  logic [31:0] prod_int;

  tkpd_pkg::div_req_t div_req;
  tkpd_pkg::div_rsp_t div_rsp;

  tkpd_div #(.FracBits(FRAC_BITS)) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  function automatic logic [31:0] qadd(input logic [31:0] a, input logic [31:0] b);
    return tkpd_pkg::sat32(66'($signed(a)) + 66'($signed(b)));
  endfunction
  function automatic logic [31:0] qsub(input logic [31:0] a, input logic [31:0] b);
    return tkpd_pkg::sat32(66'($signed(a)) - 66'($signed(b)));
  endfunction

  always_comb begin
    prod     = $signed(mul_a) * $signed(mul_b);
    // divide by 2^FRAC_BITS truncating toward zero
    pshift   = prod[63] ? -((-prod) >>> FRAC_BITS) : (prod >>> FRAC_BITS);
    prod_q   = tkpd_pkg::sat32(66'(pshift));
    prod_int = tkpd_pkg::sat32(66'(prod));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tkpd_pkg::StIdle:      if (s_axis_tvalid && s_axis_tready) state_d = tkpd_pkg::StMeas;
      tkpd_pkg::StMeas:      state_d = tkpd_pkg::StRate;
      tkpd_pkg::StRate:      state_d = tkpd_pkg::StAng0;
      tkpd_pkg::StAng0:      state_d = tkpd_pkg::StAng1;
      tkpd_pkg::StAng1:      state_d = tkpd_pkg::StCaa;
      tkpd_pkg::StCaa:       state_d = tkpd_pkg::StCab;
      tkpd_pkg::StCab:       state_d = tkpd_pkg::StCbb;
      tkpd_pkg::StCbb:       state_d = tkpd_pkg::StErr;
      tkpd_pkg::StErr:       state_d = tkpd_pkg::StDivStart;
      tkpd_pkg::StDivStart:  state_d = tkpd_pkg::StDiv0;
      tkpd_pkg::StDiv0:      if (div_rsp.done) state_d = tkpd_pkg::StDiv1Start;
      tkpd_pkg::StDiv1Start: state_d = tkpd_pkg::StDiv1;
      tkpd_pkg::StDiv1:      if (div_rsp.done) state_d = tkpd_pkg::StUpd0;
      tkpd_pkg::StUpd0:      state_d = tkpd_pkg::StUpd1;
      tkpd_pkg::StUpd1:      state_d = tkpd_pkg::StUpd2;
      tkpd_pkg::StUpd2:      state_d = tkpd_pkg::StUpd3;
      tkpd_pkg::StUpd3:      state_d = tkpd_pkg::StUpd4;
      tkpd_pkg::StUpd4:      state_d = tkpd_pkg::StUpd5;
      tkpd_pkg::StUpd5:      state_d = tkpd_pkg::StFinal;
      tkpd_pkg::StFinal:     state_d = tkpd_pkg::StPd0;
      tkpd_pkg::StPd0:       state_d = tkpd_pkg::StPd1;
      tkpd_pkg::StPd1:       state_d = tkpd_pkg::StPd2;
      tkpd_pkg::StPd2:       state_d = tkpd_pkg::StOut;
      tkpd_pkg::StOut:       state_d = tkpd_pkg::StIdle;
      default:               state_d = tkpd_pkg::StIdle;
    endcase
  end

  // datapath
  always_comb begin
    ang_d = ang_q; bias_d = bias_q; caa_d = caa_q; cab_d = cab_q;
    cba_d = cba_q; cbb_d = cbb_q;
    meas_d = meas_q; rate_d = rate_q; err_d = err_q; k0_d = k0_q; k1_d = k1_q;
    t0_d = t0_q; t1_d = t1_q; e_d = e_q; acc_d = acc_q; pacc_d = pacc_q;
    ai_d = ai_q; drive_d = drive_q; corr_d = corr_q;
    out_valid_d = out_valid_q;
    mul_a = '0;
    mul_b = '0;
    div_req.start = 1'b0;
    div_req.num   = caa_q;
    div_req.den   = e_q;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;
    case (state_q)
      tkpd_pkg::StMeas: begin
        mul_a  = 32'($signed(17'($signed(az_q)) - 17'($signed(ax_q))));
        mul_b  = accel_q;
        meas_d = prod_int;
      end
      tkpd_pkg::StRate: begin
        mul_a  = 32'(-$signed(33'($signed(gyro_q))));
        mul_b  = One;
        rate_d = prod_int;
      end
      tkpd_pkg::StAng0: begin
        mul_a = qsub(rate_q, bias_q);
        mul_b = step_q;
        ang_d = qadd(ang_q, prod_q);
        acc_d = qsub(qsub(q_angle_q, cab_q), cba_q);
      end
      tkpd_pkg::StAng1: begin
        mul_a = acc_q;
        mul_b = step_q;
        acc_d = prod_q;
      end
      tkpd_pkg::StCaa: begin
        caa_d = qadd(caa_q, acc_q);
        mul_a = tkpd_pkg::sat32(-66'($signed(cbb_q)));
        mul_b = step_q;
        cab_d = qadd(cab_q, prod_q);
        cba_d = qadd(cba_q, prod_q);
      end
      tkpd_pkg::StCab: begin
        mul_a = q_bias_q;
        mul_b = step_q;
        cbb_d = qadd(cbb_q, prod_q);
      end
      tkpd_pkg::StCbb: begin
        err_d = qsub(meas_q, ang_q);
        e_d   = qadd(r_angle_q, caa_q);
        t0_d  = caa_q;
        t1_d  = cab_q;
      end
      tkpd_pkg::StErr: ;
      tkpd_pkg::StDivStart: begin
        div_req.start = 1'b1;
        div_req.num   = caa_q;
      end
      tkpd_pkg::StDiv0: if (div_rsp.done) k0_d = div_rsp.quot;
      tkpd_pkg::StDiv1Start: begin
        div_req.start = 1'b1;
        div_req.num   = cba_q;
      end
      tkpd_pkg::StDiv1: if (div_rsp.done) k1_d = div_rsp.quot;
      tkpd_pkg::StUpd0: begin
        mul_a = k0_q; mul_b = t0_q; caa_d = qsub(caa_q, prod_q);
      end
      tkpd_pkg::StUpd1: begin
        mul_a = k0_q; mul_b = t1_q; cab_d = qsub(cab_q, prod_q);
      end
      tkpd_pkg::StUpd2: begin
        mul_a = k1_q; mul_b = t0_q; cba_d = qsub(cba_q, prod_q);
      end
      tkpd_pkg::StUpd3: begin
        mul_a = k1_q; mul_b = t1_q; cbb_d = qsub(cbb_q, prod_q);
      end
      tkpd_pkg::StUpd4: begin
        mul_a = k0_q; mul_b = err_q; ang_d = qadd(ang_q, prod_q);
      end
      tkpd_pkg::StUpd5: begin
        mul_a = k1_q; mul_b = err_q; bias_d = qadd(bias_q, prod_q);
      end
      tkpd_pkg::StFinal: begin
        corr_d = qsub(rate_q, bias_q);
        // angle to integer, toward zero, then sat16
        mul_a = ang_q;
        mul_b = 32'd1;
        if ($signed(pshift) > 64'sd32767) ai_d = 16'h7fff;
        else if ($signed(pshift) < -64'sd32768) ai_d = 16'h8000;
        else ai_d = pshift[15:0];
      end
      tkpd_pkg::StPd0: begin
        mul_a  = prop_q;
        mul_b  = 32'($signed(18'($signed(setpt_q)) - 18'($signed(ai_q))
                 + 18'($signed(vt_q))));
        pacc_d = 66'(prod);
      end
      tkpd_pkg::StPd1: begin
        mul_a  = deriv_q;
        mul_b  = 32'(-$signed(33'($signed(gyro_q))));
        pacc_d = $signed(pacc_q) - 66'(prod);
      end
      tkpd_pkg::StPd2: begin
        // sum / 2^frac toward zero, sat; negate and sat follow in StOut
        acc_d = tkpd_pkg::sat32($signed(pacc_q[65]) ? -((-$signed(pacc_q)) >>> FRAC_BITS)
                                : ($signed(pacc_q) >>> FRAC_BITS));
      end
      tkpd_pkg::StOut: begin
        drive_d     = tkpd_pkg::sat32(-66'($signed(acc_q)));
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == tkpd_pkg::StIdle) && !out_valid_q;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {corr_q, ai_q, drive_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tkpd_pkg::StIdle;
      out_valid_q <= 1'b0;
      q_angle_q   <= 32'd66;
      q_bias_q    <= 32'd197;
      r_angle_q   <= 32'd32768;
      step_q      <= 32'd328;
      accel_q     <= 32'd65536;
      prop_q      <= '0;
      deriv_q     <= '0;
      setpt_q     <= '0;
      ang_q       <= '0;
      bias_q      <= '0;
      caa_q       <= One;
      cab_q       <= '0;
      cba_q       <= '0;
      cbb_q       <= One;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ang_q <= ang_d; bias_q <= bias_d; caa_q <= caa_d;
      cab_q <= cab_d; cba_q <= cba_d; cbb_q <= cbb_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          tkpd_pkg::RegQAngle: q_angle_q <= {1'b0, cfg_data_i[30:0]};
          tkpd_pkg::RegQBias:  q_bias_q  <= {1'b0, cfg_data_i[30:0]};
          tkpd_pkg::RegRAngle: r_angle_q <= {1'b0, cfg_data_i[30:0]};
          tkpd_pkg::RegStep:   step_q    <= {1'b0, cfg_data_i[30:0]};
          tkpd_pkg::RegAccel:  accel_q   <= cfg_data_i;
          tkpd_pkg::RegProp:   prop_q    <= cfg_data_i;
          tkpd_pkg::RegDeriv:  deriv_q   <= cfg_data_i;
          tkpd_pkg::RegSetpt:  setpt_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      gyro_q <= s_axis_tdata[15:0];
      ax_q   <= s_axis_tdata[31:16];
      az_q   <= s_axis_tdata[47:32];
      vt_q   <= s_axis_tdata[63:48];
    end
    meas_q <= meas_d; rate_q <= rate_d; err_q <= err_d; k0_q <= k0_d; k1_q <= k1_d;
    t0_q <= t0_d; t1_q <= t1_d; e_q <= e_d; acc_q <= acc_d; pacc_q <= pacc_d;
    ai_q <= ai_d; drive_q <= drive_d; corr_q <= corr_d;
  end

  `TK_ASSERT_IMPL(a_busy_no_ready, clk_i, rst_ni, state_q != tkpd_pkg::StIdle, !s_axis_tready, "ready while busy")
  `TK_ASSERT_NEXT(a_out_follows, clk_i, rst_ni, state_q == tkpd_pkg::StOut, m_axis_tvalid, "no result after sequence")
  `TK_ASSERT_IMPL(a_div_idle, clk_i, rst_ni, state_q == tkpd_pkg::StIdle, !div_rsp.busy, "divider busy while idle")

endmodule

/* bench/tilt_kalman_pd_stage_tb.sv */
// Self-checking bench for the tilt Kalman PD stage: random and directed samples,
// with each result checked against a behavioural Q16.16 filter held here.
// Depends on tkpd_pkg and the tilt_kalman_pd_stage RTL.
module tilt_kalman_pd_stage_tb;

  localparam int FRAC = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    int      drive;
    shortint angle;
    int      rate;
  } tilt_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  tilt_kalman_pd_stage u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // filter configuration and state as the block should hold them
  int q_angle, q_bias, r_angle, step_time, accel_gain, prop_gain, deriv_gain, setpoint;
  int ang_est, bias_est, p_aa, p_ab, p_ba, p_bb;

  tilt_result_t expected_q[$];
  int n_errors;
  int n_sent;
  int n_checked;
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_left;
  int idle_cycles;

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int qmul(int a, int b);
    return clip32((longint'(a) * longint'(b)) / (64'sd1 <<< FRAC));
  endfunction

  function automatic int qdiv(int num, int den);
    if (den == 0) begin
      if (num > 0) return 32'h7fffffff;
      if (num < 0) return 32'h80000000;
      return 0;
    end
    return clip32((longint'(num) * (64'sd1 <<< FRAC)) / longint'(den));
  endfunction

  function automatic int qadd(int a, int b);
    return clip32(longint'(a) + longint'(b));
  endfunction

  function automatic int qsub(int a, int b);
    return clip32(longint'(a) - longint'(b));
  endfunction

  function automatic void filter_reset();
    q_angle = 66;  q_bias = 197; r_angle = 32768; step_time = 328;
    accel_gain = 65536; prop_gain = 0; deriv_gain = 0; setpoint = 0;
    ang_est = 0; bias_est = 0;
    p_aa = 1 << FRAC; p_ab = 0; p_ba = 0; p_bb = 1 << FRAC;
  endfunction

  function automatic void filter_config(logic [2:0] idx, logic [31:0] d);
    case (idx)
      tkpd_pkg::RegQAngle: q_angle = int'({1'b0, d[30:0]});
      tkpd_pkg::RegQBias:  q_bias = int'({1'b0, d[30:0]});
      tkpd_pkg::RegRAngle: r_angle = int'({1'b0, d[30:0]});
      tkpd_pkg::RegStep:   step_time = int'({1'b0, d[30:0]});
      tkpd_pkg::RegAccel:  accel_gain = int'(d);
      tkpd_pkg::RegProp:   prop_gain = int'(d);
      tkpd_pkg::RegDeriv:  deriv_gain = int'(d);
      tkpd_pkg::RegSetpt:  setpoint = int'(shortint'(d[15:0]));
      default: ;
    endcase
  endfunction

  function automatic tilt_result_t filter_step(logic [63:0] td);
    longint gyro, ax, az, vt, ai, perr, pd_sum;
    int meas, rate, d0, dneg, err, e, k0, k1, t0, t1, pd;
    tilt_result_t r;
    gyro = longint'(shortint'(td[15:0]));
    ax = longint'(shortint'(td[31:16]));
    az = longint'(shortint'(td[47:32]));
    vt = longint'(shortint'(td[63:48]));
    meas = clip32((az - ax) * longint'(accel_gain));
    rate = clip32(-gyro * (64'sd1 <<< FRAC));
    // predict
    ang_est = qadd(ang_est, qmul(qsub(rate, bias_est), step_time));
    d0 = qsub(qsub(q_angle, p_ab), p_ba);
    dneg = clip32(-longint'(p_bb));
    p_aa = qadd(p_aa, qmul(d0, step_time));
    p_ab = qadd(p_ab, qmul(dneg, step_time));
    p_ba = qadd(p_ba, qmul(dneg, step_time));
    p_bb = qadd(p_bb, qmul(q_bias, step_time));
    // correct
    err = qsub(meas, ang_est);
    e = qadd(r_angle, p_aa);
    k0 = qdiv(p_aa, e);
    k1 = qdiv(p_ba, e);
    t0 = p_aa;
    t1 = p_ab;
    p_aa = qsub(p_aa, qmul(k0, t0));
    p_ab = qsub(p_ab, qmul(k0, t1));
    p_ba = qsub(p_ba, qmul(k1, t0));
    p_bb = qsub(p_bb, qmul(k1, t1));
    ang_est = qadd(ang_est, qmul(k0, err));
    bias_est = qadd(bias_est, qmul(k1, err));
    r.rate = qsub(rate, bias_est);
    ai = longint'(ang_est) / (64'sd1 <<< FRAC);
    if (ai > 32767) ai = 32767;
    if (ai < -32768) ai = -32768;
    // PD stage
    perr = longint'(setpoint) - ai + vt;
    pd_sum = longint'(prop_gain) * perr - longint'(deriv_gain) * (-gyro);
    pd = clip32(pd_sum / (64'sd1 <<< FRAC));
    r.drive = clip32(-longint'(pd));
    r.angle = shortint'(ai);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("%0t: result %0d %s mismatch: got %0d, expected %0d",
             $realtime, n_checked, what, got, want);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result checker and receiver stalls
  always @(posedge clk_i) begin
    tilt_result_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with no sample outstanding", $realtime);
      end else begin
        w = expected_q.pop_front();
        if (int'(m_axis_tdata[31:0]) != w.drive)
          report_mismatch("drive", int'(m_axis_tdata[31:0]), w.drive);
        if (shortint'(m_axis_tdata[47:32]) != w.angle)
          report_mismatch("filtered_angle", shortint'(m_axis_tdata[47:32]), w.angle);
        if (int'(m_axis_tdata[79:48]) != w.rate)
          report_mismatch("corrected_rate", int'(m_axis_tdata[79:48]), w.rate);
      end
      n_checked++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
        $display("tilt_kalman_pd_stage_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send_sample(logic [63:0] td);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= td;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(filter_step(td));
    n_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk_i); while (!cfg_ready);
    filter_config(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                           logic [31:0] v3, logic [31:0] v4, logic [31:0] v5,
                           logic [31:0] v6, logic [31:0] v7);
    drain();
    write_reg(tkpd_pkg::RegQAngle, v0);
    write_reg(tkpd_pkg::RegQBias, v1);
    write_reg(tkpd_pkg::RegRAngle, v2);
    write_reg(tkpd_pkg::RegStep, v3);
    write_reg(tkpd_pkg::RegAccel, v4);
    write_reg(tkpd_pkg::RegProp, v5);
    write_reg(tkpd_pkg::RegDeriv, v6);
    write_reg(tkpd_pkg::RegSetpt, v7);
  endtask

  function automatic logic [63:0] pick_sample();
    logic [15:0] g, ax, az, vt;
    if ($urandom_range(99) < 70) begin
      // plausible IMU readings near upright
      g  = 16'($signed($urandom_range(4000)) - 2000);
      ax = 16'($signed($urandom_range(8000)) - 4000);
      az = 16'($signed($urandom_range(8000)) + 8000);
      vt = 16'($signed($urandom_range(600)) - 300);
    end else begin
      {g, ax} = $urandom;
      {az, vt} = $urandom;
    end
    return {vt, az, ax, g};
  endfunction

  task automatic test_directed();
    logic [15:0] ext[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    foreach (ext[i]) send_sample({ext[i], ext[3-i], ext[i], ext[i]});
    send_sample({16'h7fff, 16'h7fff, 16'h8000, 16'h8000});
    send_sample({16'h8000, 16'h8000, 16'h7fff, 16'h7fff});
    send_sample({16'h5555, 16'haaaa, 16'h5555, 16'haaaa});
    send_sample({16'haaaa, 16'h5555, 16'haaaa, 16'h5555});
    // large gains to push the PD sum and angle into saturation
    write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h00007fff);
    foreach (ext[i]) send_sample({ext[i], ext[i], ext[3-i], ext[i]});
    send_sample({16'h7fff, 16'h7fff, 16'h8000, 16'h8000});
    // zero noise and zero period: covariance collapses, divisor hits zero
    write_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h7fffffff, 32'hffff8000);
    repeat (4) send_sample(pick_sample());
    write_all(32'h0, 32'h0, 32'h0, 32'd16, 32'h0001_0000, 32'h0002_0000,
              32'hfffe_0000, 32'h0);
    repeat (6) send_sample(pick_sample());
  endtask

  task automatic test_random_phase(int items, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (items) begin
      send_sample(pick_sample());
      // quiet stretches with no idling on either side
      if ($urandom_range(99) < 3) begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end else if ($urandom_range(99) < 3) begin
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
      end
    end
  endtask

  task automatic test_random_config();
    write_all($urandom_range(2000), $urandom_range(2000),
              ($urandom_range(3) == 0) ? 32'h0 : 32'($urandom_range(131072)),
              $urandom_range(1000), $urandom_range(262144) - 131072,
              $urandom, $urandom, $urandom);
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (6) send_sample(pick_sample());
    // wait for the pipe to empty before going on
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) send_sample(pick_sample());
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = tkpd_pkg::RegQAngle;
    cfg_data = '0;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    hold_left = 0;
    idle_cycles = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    filter_reset();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    write_all(32'd66, 32'd197, 32'd32768, 32'd328, 32'd65536, 32'h0008_0000,
              32'h0000_8000, 32'h0);
    test_random_phase(150, 0, 0);
    test_random_config();
    test_random_phase(120, 85, 0);
    test_backpressure();
    test_random_config();
    test_random_phase(120, 0, 85);
    test_random_config();
    test_random_phase(120, 17, 17);
    test_random_config();
    test_random_phase(100, 85, 85);
    drain();

    $display("Covered %0d samples, %0d results checked, over extreme, zero-divisor",
             n_sent, n_checked);
    $display("and random gain settings with sender gaps and receiver stalls.");
    if (n_errors == 0) begin
      $display("tilt_kalman_pd_stage_tb: done, clean");
    end else begin
      $display("tilt_kalman_pd_stage_tb: done, errors");
    end
    $finish;
  end

endmodule
